[rtl/wwt_pkg.sv]
// ----------------------------------------------------------------------------
// I/O wait wakeup table: shared package
// Types, field widths and codes used by the table memory, the scan unit and
// the controller.
// ----------------------------------------------------------------------------
package wwt_pkg;

    // Default number of table slots.
    localparam int TABLE_DEPTH_DEF = 256;

    // Field widths.
    localparam int HANDLE_W = 16;
    localparam int WAITER_W = 16;
    localparam int LIMIT_W  = 9;
    localparam int MASK_W   = 2;

    // Limit register value after reset.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    // Item opcodes.
    localparam logic OP_PARK  = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Direction mask bits.
    localparam int DIR_READ_BIT  = 0;
    localparam int DIR_WRITE_BIT = 1;

    // One slot of the table as held in memory.
    typedef struct packed {
        logic                valid;
        logic                is_read;
        logic [HANDLE_W-1:0] handle;
        logic [WAITER_W-1:0] waiter;
    } entry_t;

    // Summary handed from the scan unit to the controller.
    typedef struct packed {
        logic done;
        logic rd_hit;
        logic wr_hit;
        logic free_found;
    } scan_status_t;

endpackage

[rtl/wwt_mem.sv]
// ----------------------------------------------------------------------------
// I/O wait wakeup table: slot memory
// Single-port-write, single-port-read synchronous memory with registered
// read data.
// ----------------------------------------------------------------------------
module wwt_mem #(
    parameter int DEPTH = wwt_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output wwt_pkg::entry_t      rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  wwt_pkg::entry_t      wr_data
);
    import wwt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/wwt_scan.sv]
// ----------------------------------------------------------------------------
// I/O wait wakeup table: scan unit
// Sweeps every slot of the memory once per item, comparing each slot with
// the handle of the current item. It records the read and write slots for
// that handle and the first free slot.
// ----------------------------------------------------------------------------
module wwt_scan #(
    parameter int DEPTH = wwt_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [wwt_pkg::HANDLE_W-1:0] key_handle,
    output logic                      rd_en,
    output logic [IDX_W-1:0]          rd_addr,
    input  wwt_pkg::entry_t           rd_data,
    output wwt_pkg::scan_status_t     status,
    output logic [IDX_W-1:0]          rd_idx,
    output logic [IDX_W-1:0]          wr_idx,
    output logic [IDX_W-1:0]          free_idx,
    output logic [wwt_pkg::WAITER_W-1:0] rd_waiter,
    output logic [wwt_pkg::WAITER_W-1:0] wr_waiter
);
    import wwt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic                active_reg;
    logic [IDX_W-1:0]    addr_reg;
    logic                pv_reg;
    logic [IDX_W-1:0]    pidx_reg;
    logic                done_reg;
    logic                rd_hit_reg;
    logic                wr_hit_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [IDX_W-1:0]    wr_idx_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [WAITER_W-1:0] rd_waiter_reg;
    logic [WAITER_W-1:0] wr_waiter_reg;
    logic                key_match;

    assign rd_en   = active_reg;
    assign rd_addr = addr_reg;

    // Read address sequencer: one slot per cycle, first to last.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            addr_reg   <= '0;
            pv_reg     <= 1'b0;
            pidx_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            pv_reg   <= active_reg;
            pidx_reg <= addr_reg;
            done_reg <= pv_reg && (pidx_reg == LAST_IDX);
            if (start)
            begin
                active_reg <= 1'b1;
                addr_reg   <= '0;
            end
            else if (active_reg)
            begin
                if (addr_reg == LAST_IDX)
                begin
                    active_reg <= 1'b0;
                end
                addr_reg <= addr_reg + 1'b1;
            end
        end
    end

    assign key_match = rd_data.valid && (rd_data.handle == key_handle);

    // Compare stage: collect matches as the read data returns.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_hit_reg     <= 1'b0;
            wr_hit_reg     <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (start)
        begin
            rd_hit_reg     <= 1'b0;
            wr_hit_reg     <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (pv_reg)
        begin
            if (key_match && rd_data.is_read)
            begin
                rd_hit_reg <= 1'b1;
            end
            if (key_match && !rd_data.is_read)
            begin
                wr_hit_reg <= 1'b1;
            end
            if (!rd_data.valid)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    // Slot indexes and waiter ids of the matches.
    always_ff @(posedge clk)
    begin
        if (pv_reg && !start)
        begin
            if (key_match && rd_data.is_read)
            begin
                rd_idx_reg    <= pidx_reg;
                rd_waiter_reg <= rd_data.waiter;
            end
            if (key_match && !rd_data.is_read)
            begin
                wr_idx_reg    <= pidx_reg;
                wr_waiter_reg <= rd_data.waiter;
            end
            if (!rd_data.valid && !free_found_reg)
            begin
                free_idx_reg <= pidx_reg;
            end
        end
    end

    assign status.done       = done_reg;
    assign status.rd_hit     = rd_hit_reg;
    assign status.wr_hit     = wr_hit_reg;
    assign status.free_found = free_found_reg;
    assign rd_idx            = rd_idx_reg;
    assign wr_idx            = wr_idx_reg;
    assign free_idx          = free_idx_reg;
    assign rd_waiter         = rd_waiter_reg;
    assign wr_waiter         = wr_waiter_reg;

endmodule

[rtl/io_wait_wakeup_table_core.sv]
// ----------------------------------------------------------------------------
// I/O wait wakeup table: top level
// Table of parked waiters keyed by handle and direction. Park items insert
// or replace a waiter; event items remove the ready directions and report
// their waiters.
//
//   Channel   Direction  Handshake                 Contents
//   in        input      in_valid / in_stall       opcode, handle, waiter_id,
//                                                  park_is_read, read_ready,
//                                                  write_ready
//   out       output     out_valid / out_stall     status, direction_mask,
//                                                  read_woken, read_waiter,
//                                                  write_woken, write_waiter
//   cfg       input      cfg_wr_en                 cfg_wr_data (table limit)
//
// Each item passes from transfer in through a scan of every slot over the
// one memory read port, then the DECIDE, WRITE2 and RESP states.
// After reset a clearing pass writes every slot empty; in_stall stays
// high during it, configuration writes are taken as ever.
// A new item is taken while the previous result still waits on out_stall;
// its result is held back until the output register is free.
// ----------------------------------------------------------------------------
module io_wait_wakeup_table_core #(
    parameter int TABLE_DEPTH = wwt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          opcode,
    input  logic [wwt_pkg::HANDLE_W-1:0]  handle,
    input  logic [wwt_pkg::WAITER_W-1:0]  waiter_id,
    input  logic                          park_is_read,
    input  logic                          read_ready,
    input  logic                          write_ready,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          status,
    output logic [wwt_pkg::MASK_W-1:0]    direction_mask,
    output logic                          read_woken,
    output logic [wwt_pkg::WAITER_W-1:0]  read_waiter,
    output logic                          write_woken,
    output logic [wwt_pkg::WAITER_W-1:0]  write_waiter,
    input  logic                          cfg_wr_en,
    input  logic [wwt_pkg::LIMIT_W-1:0]   cfg_wr_data
);
    import wwt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_WRITE2 = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [IDX_W-1:0]    clr_cnt_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [LIMIT_W-1:0]  table_limit_reg;

    logic                op_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [WAITER_W-1:0] waiter_reg;
    logic                is_read_reg;
    logic                rr_reg;
    logic                wr_reg;

    logic                res_status_reg;
    logic [MASK_W-1:0]   res_mask_reg;
    logic                res_rwk_reg;
    logic [WAITER_W-1:0] res_rw_reg;
    logic                res_wwk_reg;
    logic [WAITER_W-1:0] res_ww_reg;

    logic                out_valid_reg;
    logic                out_status_reg;
    logic [MASK_W-1:0]   out_mask_reg;
    logic                out_rwk_reg;
    logic [WAITER_W-1:0] out_rw_reg;
    logic                out_wwk_reg;
    logic [WAITER_W-1:0] out_ww_reg;

    logic                in_xfer;
    logic                out_free;
    logic                mem_rd_en;
    logic [IDX_W-1:0]    mem_rd_addr;
    entry_t              mem_rd_data;
    logic                mem_wr_en;
    logic [IDX_W-1:0]    mem_wr_addr;
    entry_t              mem_wr_data;

    scan_status_t        scan_st;
    logic [IDX_W-1:0]    scan_rd_idx;
    logic [IDX_W-1:0]    scan_wr_idx;
    logic [IDX_W-1:0]    scan_free_idx;
    logic [WAITER_W-1:0] scan_rd_waiter;
    logic [WAITER_W-1:0] scan_wr_waiter;

    logic                park_hit;
    logic [IDX_W-1:0]    park_hit_idx;
    logic                room;
    logic                park_insert;
    logic                rd_take;
    logic                wr_take;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Slot memory and scan unit.
    wwt_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    wwt_scan #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_xfer),
        .key_handle (handle_reg),
        .rd_en      (mem_rd_en),
        .rd_addr    (mem_rd_addr),
        .rd_data    (mem_rd_data),
        .status     (scan_st),
        .rd_idx     (scan_rd_idx),
        .wr_idx     (scan_wr_idx),
        .free_idx   (scan_free_idx),
        .rd_waiter  (scan_rd_waiter),
        .wr_waiter  (scan_wr_waiter)
    );

    // Decision from the scan summary.
    assign park_hit     = is_read_reg ? scan_st.rd_hit : scan_st.wr_hit;
    assign park_hit_idx = is_read_reg ? scan_rd_idx : scan_wr_idx;
    assign room         = CMP_W'(count_reg) < CMP_W'(table_limit_reg);
    assign park_insert  = !park_hit && scan_st.free_found && room;
    assign rd_take      = rr_reg && scan_st.rd_hit;
    assign wr_take      = wr_reg && scan_st.wr_hit;

    // Memory write port: clearing pass, park write, or up to two removals.
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_cnt_reg;
            end
            S_DECIDE:
            begin
                if (op_reg == OP_PARK)
                begin
                    mem_wr_en           = park_hit || park_insert;
                    mem_wr_addr         = park_hit ? park_hit_idx : scan_free_idx;
                    mem_wr_data.valid   = 1'b1;
                    mem_wr_data.is_read = is_read_reg;
                    mem_wr_data.handle  = handle_reg;
                    mem_wr_data.waiter  = waiter_reg;
                end
                else
                begin
                    mem_wr_en   = rd_take;
                    mem_wr_addr = scan_rd_idx;
                end
            end
            S_WRITE2:
            begin
                mem_wr_en   = (op_reg == OP_EVENT) && wr_take;
                mem_wr_addr = scan_wr_idx;
            end
            default:
            begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    // Entry count update.
    always_comb
    begin
        count_next = count_reg;
        if (state_reg == S_DECIDE)
        begin
            if (op_reg == OP_PARK)
            begin
                count_next = count_reg + CNT_W'(park_insert);
            end
            else
            begin
                count_next = count_reg - CNT_W'(rd_take) - CNT_W'(wr_take);
            end
        end
    end

    // Controller sequence.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_st.done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_WRITE2;
            end
            S_WRITE2:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            count_reg       <= '0;
            table_limit_reg <= LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_wr_en)
            begin
                table_limit_reg <= cfg_wr_data;
            end
        end
    end

    // Item capture on input transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg      <= opcode;
            handle_reg  <= handle;
            waiter_reg  <= waiter_id;
            is_read_reg <= park_is_read;
            rr_reg      <= read_ready;
            wr_reg      <= write_ready;
        end
    end

    // Result of the item, formed once the scan is complete.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DECIDE)
        begin
            if (op_reg == OP_PARK)
            begin
                res_rwk_reg <= 1'b0;
                res_rw_reg  <= '0;
                res_wwk_reg <= 1'b0;
                res_ww_reg  <= '0;
                if (park_hit || park_insert)
                begin
                    res_status_reg <= STATUS_OK;
                    res_mask_reg[DIR_READ_BIT]  <= scan_st.rd_hit || is_read_reg;
                    res_mask_reg[DIR_WRITE_BIT] <= scan_st.wr_hit || !is_read_reg;
                end
                else
                begin
                    res_status_reg <= STATUS_FULL;
                    res_mask_reg   <= '0;
                end
            end
            else
            begin
                res_status_reg <= STATUS_OK;
                res_mask_reg[DIR_READ_BIT]  <= scan_st.rd_hit && !rr_reg;
                res_mask_reg[DIR_WRITE_BIT] <= scan_st.wr_hit && !wr_reg;
                res_rwk_reg <= rd_take;
                res_rw_reg  <= rd_take ? scan_rd_waiter : '0;
                res_wwk_reg <= wr_take;
                res_ww_reg  <= wr_take ? scan_wr_waiter : '0;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_RESP) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_RESP) && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_mask_reg   <= res_mask_reg;
            out_rwk_reg    <= res_rwk_reg;
            out_rw_reg     <= res_rw_reg;
            out_wwk_reg    <= res_wwk_reg;
            out_ww_reg     <= res_ww_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign direction_mask = out_mask_reg;
    assign read_woken     = out_rwk_reg;
    assign read_waiter    = out_rw_reg;
    assign write_woken    = out_wwk_reg;
    assign write_waiter   = out_ww_reg;

endmodule

[rtl/wwt_checker.sv]
// ----------------------------------------------------------------------------
// I/O wait wakeup table: port checker
// Watches the result channel of the top level and checks the output
// handshake and the consistency of the result fields.
// ----------------------------------------------------------------------------
module wwt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          status,
    input logic [wwt_pkg::MASK_W-1:0]    direction_mask,
    input logic                          read_woken,
    input logic [wwt_pkg::WAITER_W-1:0]  read_waiter,
    input logic                          write_woken,
    input logic [wwt_pkg::WAITER_W-1:0]  write_waiter
);
    import wwt_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result does not change.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(direction_mask)
            && $stable(read_waiter) && $stable(write_waiter))
        else $error("stalled result changed");

    // A refused park reports no directions and wakes nobody.
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_FULL) |->
            (direction_mask == '0) && !read_woken && !write_woken)
        else $error("refused park carries wake or mask information");

    // A waiter id is reported only alongside its woken flag.
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !read_woken |-> (read_waiter == '0))
        else $error("read waiter id without read wake");

    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_woken |-> (write_waiter == '0))
        else $error("write waiter id without write wake");

endmodule

bind io_wait_wakeup_table_core wwt_checker u_wwt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .direction_mask (direction_mask),
    .read_woken     (read_woken),
    .read_waiter    (read_waiter),
    .write_woken    (write_woken),
    .write_waiter   (write_waiter)
);
